FILE: rtl/core/srt_pkg.sv
// srt_pkg: types, constants and helpers shared by the radix text converter.
// No dependencies; used by srt_dp, srt_ctrl and signed_int_to_radix_text.
`default_nettype none

package srt_pkg;

	localparam int MAX_SYMBOLS = 56;
	localparam int ALPHA_WORDS = 7;
	localparam int CHAR_W      = 8;
	localparam int BASE_W      = 6;
	localparam int VALUE_W     = 32;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int NIB_W       = 4;
	localparam int NIB_N       = VALUE_W / NIB_W;
	localparam int NCNT_W      = 4;
	localparam int NIDX_W      = 3;
	localparam int MAX_DIGITS  = 32;
	localparam int DIG_IDX_W   = 5;
	localparam int DCNT_W      = 6;
	localparam int REM_W       = BASE_W + 1;
	localparam int SEEN_N      = 128;
	localparam int SEEN_IDX_W  = 7;
	localparam int ALPHA_W     = ALPHA_WORDS * CFG_W;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FIRST = 3'd1;

	localparam logic [BASE_W-1:0] RST_BASE_LENGTH = 6'd10;
	localparam logic [CFG_W-1:0]  RST_ALPHA_0     = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0]  RST_ALPHA_1     = 64'h0000_0000_0000_3938;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_LO    = 8'd33;
	localparam logic [CHAR_W-1:0] CHAR_HI    = 8'd126;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'd0;

	typedef struct packed {
		logic load;
		logic chk_start;
		logic chk_step;
		logic div_step;
		logic emit_sign;
		logic emit_digit;
		logic emit_err;
	} cmd_t;

	typedef struct packed {
		logic chk_done;
		logic chk_ok;
		logic neg;
		logic digit_fin;
		logic q_zero;
		logic last_digit;
	} sts_t;

	// symbol k sits in byte k of the flattened alphabet
	function automatic logic [CHAR_W-1:0] symbol_at(input logic [ALPHA_W-1:0] alpha,
		input logic [BASE_W-1:0] idx);
		symbol_at = alpha[{idx, 3'b000} +: CHAR_W];
	endfunction

	// count of significant nibbles, 0 for zero
	function automatic logic [NCNT_W-1:0] sig_nibbles(input logic [VALUE_W-1:0] v);
		logic [NCNT_W-1:0] n;
		n = '0;
		for (int k = 0; k < NIB_N; k++) begin
			if (v[k*NIB_W +: NIB_W] != '0) n = NCNT_W'(k + 1);
		end
		sig_nibbles = n;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srt_dp.sv
// srt_dp: datapath - configuration registers, alphabet check scan, nibble-wide
// divider by the radix, digit stack and result register. Depends on srt_pkg.
`default_nettype none

module srt_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [srt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [srt_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic [srt_pkg::VALUE_W-1:0]      value,
	input  wire srt_pkg::cmd_t                    cmd,
	output      srt_pkg::sts_t                    sts,
	output      logic [srt_pkg::CHAR_W-1:0]       character,
	output      logic                             is_last,
	output      logic                             base_invalid
);

	logic [srt_pkg::BASE_W-1:0]                        base_q;
	logic [srt_pkg::ALPHA_WORDS-1:0][srt_pkg::CFG_W-1:0] alpha_q;
	logic [srt_pkg::ALPHA_W-1:0]                       alpha_flat;
	logic                                              chk_done_q;
	logic                                              chk_ok_q;
	logic [srt_pkg::SEEN_N-1:0]                        seen_q;
	logic [srt_pkg::BASE_W-1:0]                        chk_idx_q;
	logic [srt_pkg::CFG_IDX_W-1:0]                     word_idx;

	logic                                              neg_q;
	logic [srt_pkg::VALUE_W-1:0]                       work_q;
	logic [srt_pkg::VALUE_W-1:0]                       quo_q;
	logic [srt_pkg::BASE_W-1:0]                        rem_q;
	logic [srt_pkg::NCNT_W-1:0]                        ncnt_q;
	logic [srt_pkg::DCNT_W-1:0]                        dcnt_q;
	logic [srt_pkg::BASE_W-1:0]                        stack_q [srt_pkg::MAX_DIGITS];

	logic [srt_pkg::CHAR_W-1:0]                        char_q;
	logic                                              last_q;
	logic                                              bad_q;

	logic                                              base_bad;
	logic [srt_pkg::CHAR_W-1:0]                        chk_sym;
	logic                                              sym_bad;
	logic                                              chk_end;

	logic [srt_pkg::VALUE_W-1:0]                       mag;
	logic [srt_pkg::NIDX_W-1:0]                        nib_idx;
	logic [srt_pkg::NIB_W-1:0]                         nib;
	logic [srt_pkg::NIB_W-1:0]                         qnib;
	logic [srt_pkg::REM_W-1:0]                         rem_w;
	logic [srt_pkg::BASE_W-1:0]                        rem_next;
	logic [srt_pkg::DIG_IDX_W-1:0]                     pop_idx;

	assign alpha_flat = alpha_q;
	assign word_idx   = srt_pkg::CFG_IDX_W'(cfg_index - srt_pkg::REG_ALPHA_FIRST);

	// alphabet check, one symbol a cycle while no configuration write comes in
	assign base_bad = (base_q < srt_pkg::BASE_W'(2))
		|| (base_q > srt_pkg::BASE_W'(srt_pkg::MAX_SYMBOLS));
	assign chk_sym  = srt_pkg::symbol_at(alpha_flat, chk_idx_q);
	assign sym_bad  = (chk_sym < srt_pkg::CHAR_LO) || (chk_sym > srt_pkg::CHAR_HI)
		|| (chk_sym == srt_pkg::CHAR_MINUS) || (chk_sym == srt_pkg::CHAR_PLUS)
		|| seen_q[chk_sym[srt_pkg::SEEN_IDX_W-1:0]];
	assign chk_end  = (chk_idx_q == srt_pkg::BASE_W'(base_q - 1'b1));

	// magnitude; the most negative value maps to 2^31
	assign mag = value[srt_pkg::VALUE_W-1] ? srt_pkg::VALUE_W'(-value) : value;

	// four restoring steps over the current nibble
	assign nib_idx = srt_pkg::NIDX_W'(ncnt_q - 1'b1);
	assign nib     = work_q[{nib_idx, 2'b00} +: srt_pkg::NIB_W];

	always_comb begin
		rem_w = {1'b0, rem_q};
		qnib  = '0;
		for (int k = srt_pkg::NIB_W - 1; k >= 0; k--) begin
			rem_w = {rem_w[srt_pkg::REM_W-2:0], nib[k]};
			if (rem_w >= {1'b0, base_q}) begin
				rem_w   = srt_pkg::REM_W'(rem_w - {1'b0, base_q});
				qnib[k] = 1'b1;
			end
		end
		rem_next = rem_w[srt_pkg::BASE_W-1:0];
	end

	assign pop_idx = srt_pkg::DIG_IDX_W'(dcnt_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= srt_pkg::RST_BASE_LENGTH;
			alpha_q    <= {{(srt_pkg::ALPHA_WORDS - 2) * srt_pkg::CFG_W{1'b0}},
				srt_pkg::RST_ALPHA_1, srt_pkg::RST_ALPHA_0};
			chk_done_q <= 1'b0;
			chk_ok_q   <= 1'b0;
			seen_q     <= '0;
			chk_idx_q  <= '0;
		end else if (cfg_we) begin
			chk_done_q <= 1'b0;
			case (cfg_index)
				srt_pkg::REG_BASE_LENGTH: base_q <= cfg_data[srt_pkg::BASE_W-1:0];
				default: alpha_q[word_idx] <= cfg_data;
			endcase
		end else if (cmd.chk_start) begin
			seen_q    <= '0;
			chk_idx_q <= '0;
		end else if (cmd.chk_step && !chk_done_q) begin
			if (base_bad || sym_bad) begin
				chk_done_q <= 1'b1;
				chk_ok_q   <= 1'b0;
			end else begin
				seen_q[chk_sym[srt_pkg::SEEN_IDX_W-1:0]] <= 1'b1;
				if (chk_end) begin
					chk_done_q <= 1'b1;
					chk_ok_q   <= 1'b1;
				end else begin
					chk_idx_q <= srt_pkg::BASE_W'(chk_idx_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q <= '0;
			dcnt_q <= '0;
		end else if (cmd.load) begin
			ncnt_q <= srt_pkg::sig_nibbles(mag);
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (ncnt_q != '0) begin
				ncnt_q <= srt_pkg::NCNT_W'(ncnt_q - 1'b1);
			end else begin
				ncnt_q <= srt_pkg::sig_nibbles(quo_q);
				dcnt_q <= srt_pkg::DCNT_W'(dcnt_q + 1'b1);
			end
		end else if (cmd.emit_digit) begin
			dcnt_q <= srt_pkg::DCNT_W'(dcnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= value[srt_pkg::VALUE_W-1];
			work_q <= mag;
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			if (ncnt_q != '0) begin
				rem_q <= rem_next;
				quo_q[{nib_idx, 2'b00} +: srt_pkg::NIB_W] <= qnib;
			end else begin
				stack_q[dcnt_q[srt_pkg::DIG_IDX_W-1:0]] <= rem_q;
				work_q <= quo_q;
				quo_q  <= '0;
				rem_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= srt_pkg::CHAR_MINUS;
			last_q <= 1'b0;
			bad_q  <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= srt_pkg::symbol_at(alpha_flat, stack_q[pop_idx]);
			last_q <= (dcnt_q == srt_pkg::DCNT_W'(1));
			bad_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			char_q <= srt_pkg::CHAR_NONE;
			last_q <= 1'b1;
			bad_q  <= 1'b1;
		end
	end

	assign sts.chk_done   = chk_done_q;
	assign sts.chk_ok     = chk_ok_q;
	assign sts.neg        = neg_q;
	assign sts.digit_fin  = (ncnt_q == '0);
	assign sts.q_zero     = (quo_q == '0);
	assign sts.last_digit = (dcnt_q == srt_pkg::DCNT_W'(1));

	assign character    = char_q;
	assign is_last      = last_q;
	assign base_invalid = bad_q;

endmodule

`default_nettype wire

FILE: rtl/core/srt_ctrl.sv
// srt_ctrl: sequencing FSM - request intake, alphabet check, digit division,
// character emission and result-valid flag. Depends on srt_pkg.
`default_nettype none

module srt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire logic          out_ready,
	output      logic          out_valid,
	output      srt_pkg::cmd_t cmd,
	input  wire srt_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_SIGN  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_ERR   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       emit;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign emit     = cmd.emit_sign || cmd.emit_digit || cmd.emit_err;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.chk_done) begin
						state_d = sts.chk_ok ? S_DIV : S_ERR;
					end else begin
						cmd.chk_start = 1'b1;
						state_d       = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				cmd.chk_step = 1'b1;
				if (sts.chk_done) state_d = sts.chk_ok ? S_DIV : S_ERR;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.digit_fin && sts.q_zero) state_d = sts.neg ? S_SIGN : S_EMIT;
			end
			S_SIGN: begin
				if (out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit_digit = 1'b1;
					if (sts.last_digit) state_d = S_IDLE;
				end
			end
			S_ERR: begin
				if (out_free) begin
					cmd.emit_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_div_checked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (sts.chk_done && sts.chk_ok))
		else $error("division running on an unchecked alphabet");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/signed_int_to_radix_text.sv
// signed_int_to_radix_text: top level, joins srt_ctrl and srt_dp to the
// stream and configuration ports. Depends on srt_pkg, srt_ctrl, srt_dp.
//
//  port group   dir  payload
//  s_*          in   tdata[31:0] value
//  m_*          out  tdata[7:0] character, tlast is_last, tuser base_invalid
//  cfg_*        in   index 0 base_length, 1..7 alphabet words 0..6
//
// One request at a time; s_tready is high only while idle.
// After reset or any configuration write, the next request first scans the
// alphabet, one symbol a cycle while no configuration write comes in; the
// verdict is kept. Each digit takes a divider step for each significant nibble
// of the running quotient and then a step that stacks it; characters go out
// while m_tready is high. A stalled m_tready holds the result register and
// the emission state.
`default_nettype none

module signed_int_to_radix_text (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [srt_pkg::VALUE_W-1:0]    s_tdata,   // [31:0] value
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [srt_pkg::CHAR_W-1:0]     m_tdata,   // [7:0] character
	output      logic                           m_tlast,
	output      logic                           m_tuser,   // [0] base_invalid
	input  wire logic                           cfg_we,
	input  wire logic [srt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [srt_pkg::CFG_W-1:0]      cfg_data
);

	srt_pkg::cmd_t cmd;
	srt_pkg::sts_t sts;

	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd),
		.sts       (sts)
	);

	srt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.value        (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.character    (m_tdata),
		.is_last      (m_tlast),
		.base_invalid (m_tuser)
	);

endmodule

`default_nettype wire

FILE: tb/srt_text_checker.sv
// srt_text_checker: watches the request, character and register ports of
// signed_int_to_radix_text, predicts each character and compares it.
// Depends on srt_pkg; instantiated by tb_top.
`timescale 1ns / 100ps

module srt_text_checker
	import srt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [VALUE_W-1:0]    s_tdata,   // [31:0] value
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [CHAR_W-1:0]     m_tdata,   // [7:0] character
	input  wire logic                  m_tlast,
	input  wire logic                  m_tuser,   // [0] base_invalid
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	output int                         pending,
	output int                         mismatches
);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              bad;
	} text_char_t;

	text_char_t        expected_chars[$];
	logic [BASE_W-1:0] radix;
	logic [ALPHA_W-1:0] symbols;
	int                errors = 0;

	function automatic logic [CHAR_W-1:0] glyph(input int k);
		return symbols[k*CHAR_W +: CHAR_W];
	endfunction

	function automatic bit alphabet_valid();
		logic [CHAR_W-1:0] c;
		if (radix < 2 || radix > MAX_SYMBOLS) return 1'b0;
		for (int i = 0; i < radix; i++) begin
			c = glyph(i);
			if (c < CHAR_LO || c > CHAR_HI || c == CHAR_MINUS || c == CHAR_PLUS)
				return 1'b0;
			for (int j = i + 1; j < radix; j++)
				if (glyph(j) == c) return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_text(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] r32;
		int                 digit[MAX_DIGITS];
		int                 nd;
		text_char_t         t;
		if (!alphabet_valid()) begin
			t = '{CHAR_NONE, 1'b1, 1'b1};
			expected_chars.push_back(t);
			return;
		end
		// most negative value: -raw wraps to 2^31, taken as the magnitude
		mag = raw[VALUE_W-1] ? -raw : raw;
		r32 = VALUE_W'(radix);
		nd = 0;
		do begin
			digit[nd] = int'(mag % r32);
			mag = mag / r32;
			nd++;
		end while (mag != 0);
		if (raw[VALUE_W-1]) begin
			t = '{CHAR_MINUS, 1'b0, 1'b0};
			expected_chars.push_back(t);
		end
		for (int i = nd - 1; i >= 0; i--) begin
			t = '{glyph(digit[i]), i == 0, 1'b0};
			expected_chars.push_back(t);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			radix = RST_BASE_LENGTH;
			symbols = '0;
			symbols[CFG_W-1:0] = RST_ALPHA_0;
			symbols[2*CFG_W-1:CFG_W] = RST_ALPHA_1;
			expected_chars.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BASE_LENGTH)
					radix = cfg_data[BASE_W-1:0];
				else
					symbols[(int'(cfg_index) - int'(REG_ALPHA_FIRST))*CFG_W +: CFG_W] = cfg_data;
			end
			if (m_tvalid && m_tready) begin
				if (expected_chars.size() == 0) begin
					errors++;
					$display("%0t: unexpected character: got ch %h last %b invalid %b",
						$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = expected_chars.pop_front();
					if (m_tdata !== want.ch || m_tlast !== want.last || m_tuser !== want.bad) begin
						errors++;
						$display("%0t: expected ch %h last %b invalid %b, got ch %h last %b invalid %b",
							$time, want.ch, want.last, want.bad, m_tdata, m_tlast, m_tuser);
					end
				end
			end
			if (s_tvalid && s_tready) predict_text(s_tdata);
		end
		pending <= expected_chars.size();
		mismatches <= errors;
	end

endmodule

FILE: tb/tb_top.sv
// tb_top: clock, reset, random requests, alphabet programming and verdict for
// signed_int_to_radix_text. Depends on srt_pkg and srt_text_checker.
`timescale 1ns / 100ps

module tb_top;
	import srt_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int HOLD_CYCLES     = 400;
	localparam int POOL_N          = 92;
	localparam int DIRECTED_N      = 26;
	localparam int RANDOM_N        = 194;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [VALUE_W-1:0]   s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [CHAR_W-1:0]    m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	int                   pending;
	int                   mismatches;

	bit                   steady    = 1'b0;
	bit                   long_hold = 1'b0;
	int                   values_sent = 0;
	logic [CHAR_W-1:0]    sym_pool[POOL_N];
	logic [CFG_W-1:0]     words[ALPHA_WORDS];

	signed_int_to_radix_text u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	srt_text_checker u_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [VALUE_W-1:0] random_value(input int len);
		logic [VALUE_W-1:0] v;
		longint             p;
		int                 r;
		r = $urandom_range(0, 99);
		if (r < 35) v = $urandom;
		else if (r < 55) v = $urandom >> $urandom_range(0, 31);
		else if (r < 70) v = $urandom_range(0, 2 * len + 1);
		else if (r < 80) begin
			case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'hFFFF_FFFF;
				default: v = '0;
			endcase
		end else begin
			// neighbours of a power of the radix
			p = 1;
			repeat ($urandom_range(1, 31))
				if (p * len <= 64'h7FFF_FFFF) p = p * len;
			v = VALUE_W'(p) + VALUE_W'($urandom_range(0, 2)) - 1;
		end
		if ((r >= 35 && r < 70 || r >= 80) && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	task automatic set_byte(input int k, input logic [CHAR_W-1:0] b);
		words[k/8][(k%8)*CHAR_W +: CHAR_W] = b;
	endtask

	// distinct legal symbols in the first len places, noise beyond
	task automatic shuffle_alphabet(input int len);
		logic [CHAR_W-1:0] deck[POOL_N];
		logic [CHAR_W-1:0] tmp;
		int                j;
		deck = sym_pool;
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			j = $urandom_range(k, POOL_N - 1);
			tmp = deck[k];
			deck[k] = deck[j];
			deck[j] = tmp;
		end
		for (int w = 0; w < ALPHA_WORDS; w++) words[w] = {$urandom, $urandom};
		for (int k = 0; k < len; k++) set_byte(k, deck[k]);
	endtask

	// all eight registers, starting at a random one
	task automatic program_alphabet(input int len);
		logic [CFG_W-1:0] d;
		int               first;
		int               w;
		first = $urandom_range(0, ALPHA_WORDS);
		for (int k = 0; k <= ALPHA_WORDS; k++) begin
			w = (first + k) % (ALPHA_WORDS + 1);
			cfg_we <= 1'b1;
			if (w == ALPHA_WORDS) begin
				d = {$urandom, $urandom};
				d[BASE_W-1:0] = BASE_W'(len);
				cfg_index <= REG_BASE_LENGTH;
				cfg_data <= d;
			end else begin
				cfg_index <= REG_ALPHA_FIRST + CFG_IDX_W'(w);
				cfg_data <= words[w];
			end
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_value(input logic [VALUE_W-1:0] v);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		values_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_values(input int len, input int n);
		repeat (n) send_value(random_value(len));
		drain();
	endtask

	// receiver: ready runs, short and long stalls, and the occasional long hold-off
	initial begin
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady || $urandom_range(0, 1)) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat (idle_len() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_CYCLES) begin
				$display("signed_int_to_radix_text verification failed");
				$finish;
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] dec_vals[8];
		logic [CHAR_W-1:0]  bad_syms[4];
		int                 bad_lens[4];
		int                 n;
		int                 len;
		int                 i;
		int                 j;
		int                 phase;
		int                 r;

		dec_vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'd10,
			32'h7FFF_FFFF, 32'h8000_0000};
		bad_syms = '{CHAR_PLUS, CHAR_MINUS, 8'd32, 8'd127};
		bad_lens = '{0, 1, 57, 63};
		n = 0;
		for (int c = CHAR_LO; c <= CHAR_HI; c++)
			if (c != CHAR_PLUS && c != CHAR_MINUS) begin
				sym_pool[n] = CHAR_W'(c);
				n++;
			end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal alphabet left by reset
		foreach (dec_vals[k]) send_value(dec_vals[k]);
		drain();

		// narrowest radix, extreme symbols
		shuffle_alphabet(0);
		set_byte(0, CHAR_LO);
		set_byte(1, CHAR_HI);
		program_alphabet(2);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'hFFFF_FFFF);
		send_value(32'd0);
		drain();

		// widest radix
		shuffle_alphabet(MAX_SYMBOLS);
		program_alphabet(MAX_SYMBOLS);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'd55);
		send_value(32'd56);
		send_value(-32'd56);
		drain();

		// radix too small or beyond the symbol store
		foreach (bad_lens[k]) begin
			shuffle_alphabet(MAX_SYMBOLS);
			program_alphabet(bad_lens[k]);
			send_value($urandom);
			drain();
		end

		// illegal symbol inside the alphabet
		foreach (bad_syms[k]) begin
			shuffle_alphabet(20);
			set_byte($urandom_range(0, 19), bad_syms[k]);
			program_alphabet(20);
			send_value($urandom);
			drain();
		end

		// repeated symbol
		shuffle_alphabet(20);
		set_byte(19, words[0][CHAR_W-1:0]);
		program_alphabet(20);
		send_value(32'hFFFF_FFFF);
		drain();

		phase = 0;
		while (values_sent < DIRECTED_N + RANDOM_N) begin
			phase++;
			steady = ($urandom_range(0, 6) == 0);
			if (phase == 2 || phase == 9) begin
				steady = 1'b1;
				long_hold = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 10) len = 2;
			else if (r < 20) len = MAX_SYMBOLS;
			else len = $urandom_range(2, MAX_SYMBOLS);
			shuffle_alphabet(len);
			n = $urandom_range(6, 20);
			if ($urandom_range(0, 9) == 0) begin
				n = 3;
				case ($urandom_range(0, 2))
					0: len = ($urandom_range(0, 1)) ? $urandom_range(0, 1) : $urandom_range(57, 63);
					1: begin
						case ($urandom_range(0, 4))
							0: set_byte($urandom_range(0, len - 1), CHAR_PLUS);
							1: set_byte($urandom_range(0, len - 1), CHAR_MINUS);
							2: set_byte($urandom_range(0, len - 1), $urandom_range(0, 32));
							default: set_byte($urandom_range(0, len - 1), $urandom_range(127, 255));
						endcase
					end
					default: begin
						i = $urandom_range(1, len - 1);
						j = $urandom_range(0, i - 1);
						set_byte(i, words[j/8][(j%8)*CHAR_W +: CHAR_W]);
					end
				endcase
			end
			program_alphabet(len);
			run_values(len, n);
		end

		steady = 1'b0;
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("signed_int_to_radix_text verification clean");
		else
			$display("signed_int_to_radix_text verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/srt_pkg.sv
rtl/core/srt_dp.sv
rtl/core/srt_ctrl.sv
rtl/core/signed_int_to_radix_text.sv
tb/srt_text_checker.sv
tb/tb_top.sv
